// File: sv/sha_pkg.sv
// Package: shared types and constants for the SHA-256 byte stream hash.
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_LEN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic put_byte;
        logic put_pad;
        logic clear_tail;
        logic clear_all;
        logic put_len;
        logic start_comp;
        logic round_step;
        logic fold;
        logic reset_msg;
        logic emit_load;
        logic emit_shift;
    } cmd_t;

    typedef struct packed {
        logic [5:0] byte_count;
        logic       round_done;
    } status_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_LIMIT = 6'd56;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] v);
        bsig0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] v);
        bsig1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] v);
        ssig0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] v);
        ssig1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
    endfunction

endpackage

// File: sv/sha_if.sv
// Interfaces: valid/ready channels for input bytes and digest words.
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;
    modport source (output valid, data_byte, byte_valid, last_byte, input ready);
    modport sink (input valid, data_byte, byte_valid, last_byte, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: sv/sha256_byte_stream_hash.sv
// Top level: SHA-256 hash over a byte stream with a digest word output channel.
// Bytes are taken while idle; a full 64-byte block then stalls input for
// 64 rounds on the single round unit plus one fold. A last item adds a pad
// step, a length step, the rounds and fold of each remaining block, and then
// eight digest words, one per accepted output handshake.
module sha256_byte_stream_hash (
    input  logic  clk,
    input  logic  rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);

    sha_pkg::cmd_t    cmd;
    sha_pkg::status_t status;

    sha_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_ch.valid),
        .in_byte_valid (in_ch.byte_valid),
        .in_last       (in_ch.last_byte),
        .in_ready      (in_ch.ready),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .out_index     (out_ch.word_index),
        .status        (status),
        .cmd           (cmd)
    );

    sha_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_byte     (in_ch.data_byte),
        .cmd         (cmd),
        .status      (status),
        .digest_word (out_ch.digest_word)
    );

    assign out_ch.last_word = out_ch.word_index == 3'd7;

endmodule

// File: sv/sha_ctrl.sv
// Controller: sequences byte intake, padding, compression and digest output.
module sha_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_byte_valid,
    input  logic            in_last,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [2:0]      out_index,
    input  sha_pkg::status_t status,
    output sha_pkg::cmd_t   cmd
);

    sha_pkg::state_t state_reg, state_next;
    logic            pend_last_reg, pend_last_next;
    logic            len_after_reg, len_after_next;
    logic            need_len_reg, need_len_next;
    logic [2:0]      idx_reg, idx_next;

    logic            accept;
    logic            fills;
    logic            out_fire;

    assign accept   = in_valid && in_ready;
    assign fills    = in_byte_valid && (status.byte_count == 6'd63);
    assign out_fire = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha_pkg::ST_IDLE;
            pend_last_reg <= 1'b0;
            len_after_reg <= 1'b0;
            need_len_reg  <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_last_reg <= pend_last_next;
            len_after_reg <= len_after_next;
            need_len_reg  <= need_len_next;
            idx_reg       <= idx_next;
        end
    end

    // next state
    always_comb
    begin
        state_next     = state_reg;
        pend_last_next = pend_last_reg;
        len_after_next = len_after_reg;
        need_len_next  = need_len_reg;
        idx_next       = idx_reg;
        case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    pend_last_next = in_last;
                    len_after_next = 1'b0;
                    need_len_next  = 1'b0;
                    if (fills)
                        state_next = sha_pkg::ST_ROUND;
                    else if (in_last)
                        state_next = sha_pkg::ST_PAD;
                end
            end
            sha_pkg::ST_ROUND:
            begin
                if (status.round_done)
                    state_next = sha_pkg::ST_FOLD;
            end
            sha_pkg::ST_FOLD:
            begin
                if (len_after_reg)
                begin
                    idx_next   = '0;
                    state_next = sha_pkg::ST_EMIT;
                end
                else if (pend_last_reg)
                    state_next = sha_pkg::ST_PAD;
                else if (need_len_reg)
                    state_next = sha_pkg::ST_LEN;
                else
                    state_next = sha_pkg::ST_IDLE;
            end
            sha_pkg::ST_PAD:
            begin
                if (status.byte_count >= sha_pkg::LEN_LIMIT)
                begin
                    pend_last_next = 1'b0;
                    need_len_next  = 1'b1;
                    state_next     = sha_pkg::ST_ROUND;
                end
                else
                    state_next = sha_pkg::ST_LEN;
            end
            sha_pkg::ST_LEN:
            begin
                len_after_next = 1'b1;
                need_len_next  = 1'b0;
                state_next     = sha_pkg::ST_ROUND;
            end
            sha_pkg::ST_EMIT:
            begin
                if (out_fire)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                        state_next = sha_pkg::ST_IDLE;
                end
            end
            default: state_next = sha_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.put_byte = accept && in_byte_valid;
                cmd.start_comp = accept && fills;
            end
            sha_pkg::ST_ROUND:
                cmd.round_step = 1'b1;
            sha_pkg::ST_FOLD:
            begin
                cmd.fold = 1'b1;
                cmd.emit_load = len_after_reg;
            end
            sha_pkg::ST_PAD:
            begin
                cmd.put_pad    = 1'b1;
                cmd.clear_tail = 1'b1;
                cmd.start_comp = status.byte_count >= sha_pkg::LEN_LIMIT;
            end
            sha_pkg::ST_LEN:
            begin
                cmd.put_len    = 1'b1;
                cmd.clear_all  = need_len_reg;
                cmd.start_comp = 1'b1;
            end
            sha_pkg::ST_EMIT:
            begin
                out_valid      = 1'b1;
                cmd.emit_shift = out_fire;
                cmd.reset_msg  = out_fire && (idx_reg == 3'd7);
            end
            default: cmd = '0;
        endcase
    end

    assign out_index = idx_reg;

endmodule

// File: sv/sha_dp.sv
// Datapath: schedule window, round logic, chaining value and digest shifter.
module sha_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       in_byte,
    input  sha_pkg::cmd_t    cmd,
    output sha_pkg::status_t status,
    output logic [31:0]      digest_word
);

    logic [31:0] w_reg [16];
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] d_reg [8];
    logic [5:0]  cnt_reg;
    logic [63:0] len_reg;
    logic [6:0]  rnd_reg;

    logic [3:0]  bw;
    logic [1:0]  lane;
    logic [31:0] wt, t1, t2;
    logic [3:0]  ti;
    logic [7:0]  pb;

    assign bw   = cnt_reg[5:2];
    assign lane = cnt_reg[1:0];
    assign ti   = rnd_reg[3:0];
    assign pb   = cmd.put_pad ? sha_pkg::PAD_BYTE : in_byte;

    always_comb
    begin
        if (rnd_reg < 7'd16)
            wt = w_reg[ti];
        else
            wt = sha_pkg::ssig1(w_reg[ti - 4'd2]) + w_reg[ti - 4'd7]
               + sha_pkg::ssig0(w_reg[ti - 4'd15]) + w_reg[ti];
        t1 = v_reg[7] + sha_pkg::bsig1(v_reg[4])
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + sha_pkg::ROUND_K[rnd_reg[5:0]] + wt;
        t2 = sha_pkg::bsig0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.put_byte || cmd.put_pad)
        begin
            case (lane)
                2'd0: w_reg[bw] <= {pb, 24'h0};
                2'd1: w_reg[bw] <= {w_reg[bw][31:24], pb, 16'h0};
                2'd2: w_reg[bw] <= {w_reg[bw][31:16], pb, 8'h0};
                default: w_reg[bw] <= {w_reg[bw][31:8], pb};
            endcase
        end
        if (cmd.clear_tail)
            for (int i = 0; i < 16; i++)
                if (4'(i) > bw)
                    w_reg[i] <= '0;
        if (cmd.clear_all)
            for (int i = 0; i < 14; i++)
                w_reg[i] <= '0;
        if (cmd.put_len)
        begin
            w_reg[14] <= len_reg[63:32];
            w_reg[15] <= len_reg[31:0];
        end
        if (cmd.round_step && rnd_reg >= 7'd16)
            w_reg[ti] <= wt;
        if (cmd.emit_load)
            for (int i = 0; i < 8; i++)
                d_reg[i] <= h_reg[i] + v_reg[i];
        else if (cmd.emit_shift)
            for (int i = 0; i < 7; i++)
                d_reg[i] <= d_reg[i + 1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha_pkg::INIT_H[i];
                v_reg[i] <= '0;
            end
            cnt_reg <= '0;
            len_reg <= '0;
            rnd_reg <= '0;
        end
        else
        begin
            if (cmd.put_byte)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                len_reg <= len_reg + 64'd8;
            end
            if (cmd.start_comp)
            begin
                rnd_reg <= '0;
                for (int i = 0; i < 8; i++)
                    v_reg[i] <= h_reg[i];
            end
            else if (cmd.round_step)
            begin
                rnd_reg <= rnd_reg + 7'd1;
                for (int i = 1; i < 8; i++)
                    v_reg[i] <= v_reg[i - 1];
                v_reg[0] <= t1 + t2;
                v_reg[4] <= v_reg[3] + t1;
            end
            if (cmd.fold)
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
            if (cmd.reset_msg)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= sha_pkg::INIT_H[i];
                cnt_reg <= '0;
                len_reg <= '0;
            end
        end
    end

    assign status.byte_count = cnt_reg;
    assign status.round_done = rnd_reg == 7'd63;
    assign digest_word       = d_reg[0];

endmodule

// File: sv/sha_chk.sv
// Checker: port-level properties of the hash block, bound to the top level.
module sha_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  word_index,
    input logic        last_word
);

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while digest shown");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd7)))
        else $error("last_word mismatch");

    a_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && word_index != 3'd7) |=>
        (out_valid && word_index == $past(word_index) + 3'd1))
        else $error("digest index did not advance");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(word_index)))
        else $error("stalled word changed");

endmodule

bind sha256_byte_stream_hash sha_chk u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .word_index (out_ch.word_index),
    .last_word  (out_ch.last_word)
);
